[hw/rtl/indexed_list_insert_erase_unit_macros.svh]
// Assertion helpers for the list RTL.
`ifndef INDEXED_LIST_INSERT_ERASE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_ERASE_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ILIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off while in reset.
`define ILIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/ilie_pkg.sv]
package ilie_pkg;

  localparam int FUNC_W    = 3;
  localparam int POS_W     = 6;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [WORD_W-1:0] WORD_ERR = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_READ   = 3'd2,
    FN_REMOVE = 3'd3,
    FN_ERASE  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;  // insert/append: cells at/above index move up
    logic shift_dn;  // erase: cells at/above index take right neighbor
  } cell_op_t;

endpackage

[hw/rtl/ilie_in_if.sv]
interface ilie_in_if import ilie_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, output func, output position, output word_in, input ready);
  modport sink   (input valid, input func, input position, input word_in, output ready);
endinterface

[hw/rtl/ilie_out_if.sv]
interface ilie_out_if import ilie_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   word_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output word_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input word_out, input status, input entry_count,
                  output ready);
endinterface

[hw/rtl/indexed_list_insert_erase_unit.sv]
// The result is registered and is valid in the cycle after the input transfer.
// Throughput: 1 request per cycle unless the output stalls; every cell of the shift chain
// moves in the same cycle, so insert and erase cost no more than read.
// A new request is taken while the result register is empty or being drained.
// Reset (rst_n low, synchronous): entry count to zero, result register empty,
// no input taken; stored words are not cleared.
`include "indexed_list_insert_erase_unit_macros.svh"

module indexed_list_insert_erase_unit import ilie_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ilie_in_if.sink    in_ch,
  ilie_out_if.source out_ch
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                acc;
  func_t               fn;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                full;
  logic                empty;
  cell_op_t            op;
  logic [IDX_W-1:0]    sel_idx;
  status_t             res_status;
  logic [WORD_W-1:0]   res_word;
  logic [WORD_W-1:0]   rd_word;

  logic [WORD_W-1:0]   cell_data [DEPTH];
  logic [WORD_W-1:0]   cell_rd   [DEPTH];

  assign in_ch.ready = rst_n & (~out_valid_r | out_ch.ready);
  assign acc         = in_ch.valid & in_ch.ready;

  assign fn      = func_t'(in_ch.func);
  assign pos_ext = CMP_W'(in_ch.position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);

  // Read bus: at most one cell is addressed.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

  always_comb begin
    op         = '0;
    sel_idx    = IDX_W'(in_ch.position);
    res_status = ST_OK;
    res_word   = '0;
    count_nxt  = count_r;
    unique case (fn)
      FN_APPEND: begin
        sel_idx = IDX_W'(count_r);
        if (full) begin
          res_status = ST_FULL;
          res_word   = WORD_ERR;
        end else begin
          op.shift_up = 1'b1;
          count_nxt   = count_r + CNT_ONE;
        end
      end
      FN_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
          res_word   = WORD_ERR;
        end else if (pos_ext > cnt_ext) begin
          res_status = ST_RANGE;
          res_word   = WORD_ERR;
        end else begin
          op.shift_up = 1'b1;
          count_nxt   = count_r + CNT_ONE;
        end
      end
      FN_READ: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_RANGE;
          res_word   = WORD_ERR;
        end else begin
          res_word = rd_word;
        end
      end
      FN_REMOVE: begin
        if (empty) begin
          res_status = ST_EMPTY;
          res_word   = WORD_ERR;
        end else begin
          count_nxt = count_r - CNT_ONE;
        end
      end
      FN_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_RANGE;
          res_word   = WORD_ERR;
        end else begin
          op.shift_dn = 1'b1;
          count_nxt   = count_r - CNT_ONE;
        end
      end
      default: begin
        res_status = ST_OK;
        res_word   = '0;
      end
    endcase
    if (!acc) begin
      op        = '0;
      count_nxt = count_r;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = in_ch.word_in;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    ilie_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .sel_idx (sel_idx),
      .word    (in_ch.word_in),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_word_r   <= res_word;
      out_status_r <= res_status;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.word_out    = out_word_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

  `ILIE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL)
  `ILIE_ASSERT_NXT(a_append_grows, clk, rst_n, acc && fn == FN_APPEND && !full, count_r == $past(count_r) + CNT_ONE)
  `ILIE_ASSERT_IMP(a_err_word, clk, rst_n, out_valid_r && out_status_r != ST_OK, out_word_r == WORD_ERR)
  `ILIE_ASSERT_NXT(a_shift_excl, clk, rst_n, op.shift_up, !$past(op.shift_dn))

endmodule

[hw/rtl/ilie_cell.sv]
module ilie_cell import ilie_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [IDX_W-1:0]  sel_idx,
  input  logic [WORD_W-1:0] word,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  output logic [WORD_W-1:0] data_o,
  output logic [WORD_W-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              eq;
  logic              ge;

  assign eq = (MY_IDX == sel_idx);
  assign ge = (MY_IDX >= sel_idx);

  always_comb begin
    data_nxt = data_r;
    priority if (op.shift_up) begin
      if (eq) begin
        data_nxt = word;
      end else if (ge) begin
        data_nxt = left_i;
      end
    end else if (op.shift_dn) begin
      if (ge) begin
        data_nxt = right_i;
      end
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // Only the addressed cell contributes to the read bus.
  assign rd_o   = data_r & {WORD_W{eq}};

endmodule
